// ----- sv/iradx_pkg.sv -----
// Shared constants, types and codes for the integer-to-radix-digits block.
package iradx_pkg;

    // Field and alphabet sizes
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_RADIX   = 16;
    localparam int ALPHA_SLOTS = 16;
    localparam int CHAR_WIDTH  = 8;
    localparam int CFG_WIDTH   = 64;
    localparam int RADIX_WIDTH = 5;
    localparam int DIGIT_WIDTH = $clog2(MAX_RADIX);

    // Digit stack holds one digit per bit of magnitude at most (base two)
    localparam int STACK_DEPTH = VALUE_WIDTH;
    localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);
    localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);

    // Special characters
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIX      = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_WIDTH-1:0] remainder;
    } div_result_t;

endpackage

// ----- sv/iradx_alpha_check.sv -----
// Alphabet check: length in range, no repeated characters, no sign characters.
module iradx_alpha_check
    import iradx_pkg::*;
(
    input  logic [CFG_WIDTH-1:0]   alphabet_low,
    input  logic [CFG_WIDTH-1:0]   alphabet_high,
    input  logic [RADIX_WIDTH-1:0] radix,
    output logic                   ok
);

    logic [2*CFG_WIDTH-1:0] alpha_all;
    logic [CHAR_WIDTH-1:0]  chars [ALPHA_SLOTS];
    logic                   bad;

    assign alpha_all = {alphabet_high, alphabet_low};

    // Split into characters
    always_comb
    begin
        for (int i = 0; i < ALPHA_SLOTS; i++)
        begin
            chars[i] = alpha_all[i*CHAR_WIDTH +: CHAR_WIDTH];
        end
    end

    // Pairwise and sign checks over the characters in use
    always_comb
    begin
        bad = 1'b0;
        for (int i = 0; i < ALPHA_SLOTS; i++)
        begin
            if (RADIX_WIDTH'(i) < radix)
            begin
                if (chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS)
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < ALPHA_SLOTS; j++)
                begin
                    if (RADIX_WIDTH'(j) < radix && chars[j] == chars[i])
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign ok = !bad && (radix >= RADIX_WIDTH'(2))
                && (radix <= RADIX_WIDTH'(MAX_RADIX))
                && (radix <= RADIX_WIDTH'(ALPHA_SLOTS));

endmodule

// ----- sv/iradx_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module iradx_divider
    import iradx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_WIDTH-1:0] divisor,
    output div_result_t            result
);

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [DIGIT_WIDTH-1:0] rem_reg;
    logic [DIGIT_WIDTH-1:0] rem_next;
    logic [STEP_WIDTH-1:0]  step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [RADIX_WIDTH-1:0] trial;
    logic [RADIX_WIDTH-1:0] diff;
    logic                   fits;

    // One step: bring down the next dividend bit, subtract if it fits
    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits     = trial >= divisor;
    assign diff     = trial - divisor;
    assign rem_next = fits ? diff[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
    assign quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_WIDTH'(VALUE_WIDTH - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Quotient and remainder shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

// ----- sv/iradx_digit_stack.sv -----
// Digit LIFO built as a shift register; the newest digit sits at the low end.
module iradx_digit_stack
    import iradx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   pop,
    input  logic [DIGIT_WIDTH-1:0] digit,
    output logic [DIGIT_WIDTH-1:0] top,
    output logic [COUNT_WIDTH-1:0] count
);

    localparam int STACK_BITS = STACK_DEPTH * DIGIT_WIDTH;

    logic [STACK_BITS-1:0]  stack_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // Digit storage: push shifts up, pop shifts down
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg <= {stack_reg[STACK_BITS-DIGIT_WIDTH-1:0], digit};
        end
        else if (pop)
        begin
            stack_reg <= {{DIGIT_WIDTH{1'b0}}, stack_reg[STACK_BITS-1:DIGIT_WIDTH]};
        end
    end

    assign top   = stack_reg[DIGIT_WIDTH-1:0];
    assign count = count_reg;

endmodule

// ----- sv/integer_to_radix_digits_top.sv -----
// Integer to radix digits converter: top level with sequencer and registers.
//
// Converts a signed 32-bit value to text in the configured base, one character
// per output item, the final character flagged by last. Digits are found by a
// bit-serial divider that makes 32 shift steps per digit and then hands the
// digit over, least significant first, and are held in a digit stack so they
// leave most significant first, after a leading minus for a negative value.
// One value is handled at a time; a new value is taken once the last character
// of the previous one is in the output register. While the alphabet is invalid
// (length below 2 or above 16, a repeated character, or a '+' or '-' in use),
// values are taken and dropped without output. Write configuration only while
// the block is idle.
module integer_to_radix_digits_top
    import iradx_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    // Input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [VALUE_WIDTH-1:0] value,
    // Output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [CHAR_WIDTH-1:0]      character,
    output logic                       last
);

    logic [CFG_WIDTH-1:0]   alpha_low_reg;
    logic [CFG_WIDTH-1:0]   alpha_high_reg;
    logic [RADIX_WIDTH-1:0] radix_reg;

    state_t                 state_reg;
    state_t                 state_next;
    logic                   neg_reg;
    logic                   out_valid_reg;
    logic [CHAR_WIDTH-1:0]  char_reg;
    logic                   last_reg;

    logic                   alpha_ok;
    logic                   accept;
    logic                   slot_free;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    div_result_t            div_res;
    logic                   push;
    logic                   pop;
    logic [DIGIT_WIDTH-1:0] top_digit;
    logic [COUNT_WIDTH-1:0] digit_count;
    logic                   load_out;
    logic [CHAR_WIDTH-1:0]  load_char;
    logic                   load_last;
    logic [2*CFG_WIDTH-1:0] alpha_all;
    logic [CHAR_WIDTH-1:0]  digit_char;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            radix_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                CFG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                CFG_RADIX:      radix_reg      <= cfg_data[RADIX_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    iradx_alpha_check u_check (
        .alphabet_low  (alpha_low_reg),
        .alphabet_high (alpha_high_reg),
        .radix         (radix_reg),
        .ok            (alpha_ok)
    );

    // Magnitude of the input; the most negative value wraps to its unsigned size
    assign magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    iradx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .result   (div_res)
    );

    iradx_digit_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .digit (div_res.remainder),
        .top   (top_digit),
        .count (digit_count)
    );

    // Alphabet lookup for the digit on top of the stack
    assign alpha_all  = {alpha_high_reg, alpha_low_reg};
    assign digit_char = alpha_all[top_digit*CHAR_WIDTH +: CHAR_WIDTH];

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                neg_reg <= value[VALUE_WIDTH-1];
            end
        end
    end

    // Sequencer next state and controls
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = div_res.quotient;
        push         = 1'b0;
        pop          = 1'b0;
        load_out     = 1'b0;
        load_char    = CHAR_MINUS;
        load_last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                div_dividend = magnitude;
                if (in_valid && alpha_ok)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    push = 1'b1;
                    if (div_res.quotient != '0)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load_out  = 1'b1;
                    load_char = digit_char;
                    load_last = (digit_count == COUNT_WIDTH'(1));
                    pop       = 1'b1;
                    if (digit_count == COUNT_WIDTH'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            char_reg <= load_char;
            last_reg <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule
